[hdl/polynomial_string_hash_assert.svh]
// Assertion macros shared by the polynomial string hash RTL.
// Expects clk_i and rst_ni to be visible in the including module.
`ifndef POLYNOMIAL_STRING_HASH_ASSERT_SVH
`define POLYNOMIAL_STRING_HASH_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PSH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/psh_pkg.sv]
// Package for the polynomial string hash: widths, register indexes,
// mode decode, sequencer states and the reducer status struct. No dependencies.
`timescale 1ns / 1ps

package psh_pkg;

  localparam int unsigned MOD_WIDTH_DEF = 16;
  localparam int unsigned HASH_W        = 16;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned LETTER_W      = 5;
  // Width of the small multiplier operand (letter value or base)
  localparam int unsigned MUL_B_W       = 6;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned SHIFT_W       = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE  = 2'd1;

  localparam logic [31:0] TABLE_SIZE_RST = 32'd5003;

  // ASCII range of lowercase letters; 'a' maps to letter value 1
  localparam logic [CHAR_W-1:0] LETTER_FIRST  = 7'd97;
  localparam logic [CHAR_W-1:0] LETTER_LAST   = 7'd122;
  localparam logic [CHAR_W-1:0] LETTER_OFFSET = 7'd96;

  // Hash modes
  localparam logic [1:0] MODE_B31 = 2'd0;
  localparam logic [1:0] MODE_B7  = 2'd1;
  localparam logic [1:0] MODE_B37 = 2'd2;

  typedef struct packed {
    logic [MUL_B_W-1:0] base;
    logic [SHIFT_W-1:0] shift;
  } mode_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } red_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_H,
    ST_RED_H,
    ST_MUL_P,
    ST_RED_P,
    ST_DONE
  } psh_state_e;

  // Base and pre-shift per mode; the unused code behaves as base 31
  function automatic mode_cfg_t mode_decode(logic [1:0] mode);
    mode_cfg_t c;
    unique case (mode)
      MODE_B7: begin
        c.base  = 6'd7;
        c.shift = 3'd2;
      end
      MODE_B37: begin
        c.base  = 6'd37;
        c.shift = 3'd4;
      end
      default: begin
        c.base  = 6'd31;
        c.shift = 3'd0;
      end
    endcase
    return c;
  endfunction

endpackage

[hdl/psh_if.sv]
// Channel interfaces of the polynomial string hash: letters in, hashes out,
// configuration writes. Depends on psh_pkg.
`timescale 1ns / 1ps

interface psh_char_if import psh_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface psh_hash_if import psh_pkg::*;;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

interface psh_cfg_if import psh_pkg::*; #(
  parameter int unsigned DATA_W = MOD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/psh_reducer.sv]
// Iterative modulo reducer: restoring remainder, one dividend bit per cycle.
// Depends on psh_pkg and polynomial_string_hash_assert.svh.
`timescale 1ns / 1ps
`include "polynomial_string_hash_assert.svh"

module psh_reducer import psh_pkg::*; #(
  parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [MOD_WIDTH+MUL_B_W-1:0] dividend_i,
  input  logic [MOD_WIDTH-1:0]         modulus_i,
  output red_stat_t                    stat_o,
  output logic [MOD_WIDTH-1:0]         rem_o
);

  localparam int unsigned DvdW  = MOD_WIDTH + MUL_B_W;
  localparam int unsigned CntW  = $clog2(DvdW + 1);
  localparam logic [CntW-1:0] StepsC = CntW'(DvdW);
  localparam logic [CntW-1:0] OneC   = CntW'(1);

  logic [DvdW-1:0]      dvd_q;
  logic [MOD_WIDTH-1:0] rem_q, rem_d;
  logic [MOD_WIDTH-1:0] mod_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, done_q;
  logic [MOD_WIDTH:0]   trial;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[DvdW-1]};
    if (trial >= {1'b0, mod_q}) begin
      rem_d = MOD_WIDTH'(trial - {1'b0, mod_q});
    end else begin
      rem_d = trial[MOD_WIDTH-1:0];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= StepsC;
    end else if (busy_q) begin
      cnt_q <= cnt_q - OneC;
      if (cnt_q == OneC) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      mod_q <= modulus_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

  `PSH_ASSERT_IMPLIES(a_rem_below_mod, done_q, rem_q < mod_q, "remainder not below modulus")
  `PSH_ASSERT_IMPLIES(a_no_restart_busy, start_i, !busy_q, "reducer started while busy")

endmodule

[hdl/polynomial_string_hash.sv]
// Polynomial string hash top level: config registers, sequencer, shared
// multiplier and output register. Depends on psh_pkg, psh_if, psh_reducer.
//
// Usage:
//   cfg_i  : register writes (index 0 table_size, index 1 hash_mode), always
//            ready; write only while the block is idle.
//   char_i : one lowercase letter per beat plus a last-letter flag. Codes
//            outside 'a'..'z' are dropped in the accepting cycle, state untouched.
//   hash_o : one beat per word, the hash below table_size (table_size 0 or 1
//            acts as 2).
// Each letter runs two reductions (hash, then power) through one shared
// multiplier and one bit-serial reducer, one dividend bit per cycle. char_i is
// ready again only once the letter has gone through both reductions and the
// sequencer is back in idle. The last letter's final step loads the hash into
// the output register that drives hash_o and holds it until it is taken.
// A pending result sits in an output register; if it is still not taken when
// the next word finishes, the block holds in its final step until it is.
// Reset: table_size 5003, mode 0 (base 31), hash 0, power 1, no result.
`timescale 1ns / 1ps
`include "polynomial_string_hash_assert.svh"

module polynomial_string_hash import psh_pkg::*; #(
  parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psh_cfg_if.sink     cfg_i,
  psh_char_if.sink    char_i,
  psh_hash_if.source  hash_o
);

  localparam int unsigned DvdW = MOD_WIDTH + MUL_B_W;
  localparam logic [MOD_WIDTH-1:0] ModMin  = MOD_WIDTH'(2);
  localparam logic [MOD_WIDTH-1:0] PowerOne = MOD_WIDTH'(1);

  psh_state_e           state_q, state_d;
  logic [MOD_WIDTH-1:0] table_size_q;
  logic [1:0]           hash_mode_q;
  logic [MOD_WIDTH-1:0] hash_q, hash_d;
  logic [MOD_WIDTH-1:0] power_q, power_d;
  logic                 out_valid_q, out_valid_d;
  logic [HASH_W-1:0]    out_hash_q, out_hash_d;

  logic [LETTER_W-1:0]  letter_q;
  logic                 last_q;
  mode_cfg_t            mcfg_q;
  logic [MOD_WIDTH-1:0] mod_q;

  logic                 char_ready;
  logic                 char_fire;
  logic                 char_ok;
  logic [CHAR_W-1:0]    letter_full;
  logic [MOD_WIDTH-1:0] eff_mod;

  logic [MUL_B_W-1:0]   mul_b;
  logic [MOD_WIDTH-1:0] addend;
  logic [DvdW-1:0]      dividend;
  logic                 red_start;
  red_stat_t            red_stat;
  logic [MOD_WIDTH-1:0] red_rem;

  logic                 word_end;
  logic                 word_reset;
  logic                 power_done;
  logic                 in_reduce;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST[MOD_WIDTH-1:0];
      hash_mode_q  <= MODE_B31;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_TABLE_SIZE: table_size_q <= cfg_i.data;
        CFG_HASH_MODE:  hash_mode_q  <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  // Input beat
  assign char_ready  = (state_q == ST_IDLE);
  assign char_i.ready = char_ready;
  assign char_fire   = char_i.valid && char_ready;
  assign char_ok     = (char_i.char_code >= LETTER_FIRST) &&
                       (char_i.char_code <= LETTER_LAST);
  assign letter_full = char_i.char_code - LETTER_OFFSET;
  assign eff_mod     = (table_size_q < ModMin) ? ModMin : table_size_q;

  // Per-letter operands, captured at accept
  always_ff @(posedge clk_i) begin
    if (char_fire && char_ok) begin
      letter_q <= letter_full[LETTER_W-1:0];
      last_q   <= char_i.last_char;
      mcfg_q   <= mode_decode(hash_mode_q);
      mod_q    <= eff_mod;
    end
  end

  // Shared multiplier: letter*power + shifted hash, or power*base
  assign mul_b  = (state_q == ST_MUL_H) ? MUL_B_W'(letter_q) : mcfg_q.base;
  assign addend = (state_q == ST_MUL_H) ? (hash_q >> mcfg_q.shift) : '0;
  assign dividend = DvdW'(power_q) * DvdW'(mul_b) + DvdW'(addend);

  psh_reducer #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_reducer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (red_start),
    .dividend_i (dividend),
    .modulus_i  (mod_q),
    .stat_o     (red_stat),
    .rem_o      (red_rem)
  );

  // Sequencer: next state, state updates, result hand-off
  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    power_d     = power_q;
    out_valid_d = out_valid_q && !hash_o.ready;
    out_hash_d  = out_hash_q;
    red_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (char_fire && char_ok) state_d = ST_MUL_H;
      end
      ST_MUL_H: begin
        red_start = 1'b1;
        state_d   = ST_RED_H;
      end
      ST_RED_H: begin
        if (red_stat.done) begin
          hash_d  = red_rem;
          state_d = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        red_start = 1'b1;
        state_d   = ST_RED_P;
      end
      ST_RED_P: begin
        if (red_stat.done) begin
          power_d = red_rem;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || hash_o.ready) begin
          out_valid_d = 1'b1;
          out_hash_d  = HASH_W'(hash_q);
          hash_d      = '0;
          power_d     = PowerOne;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hash_q      <= '0;
      power_q     <= PowerOne;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      power_q     <= power_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hash_q <= out_hash_d;
  end

  assign hash_o.valid      = out_valid_q;
  assign hash_o.hash_value = out_hash_q;

  // Checker terms
  assign word_end   = (state_q == ST_DONE) && last_q && (state_d == ST_IDLE);
  assign word_reset = (hash_q == '0) && (power_q == PowerOne);
  assign power_done = (state_q == ST_RED_P) && red_stat.done;
  assign in_reduce  = (state_q == ST_RED_H) || (state_q == ST_RED_P);

  `PSH_ASSERT_NEXT(a_word_restart, word_end, word_reset && out_valid_q, "word did not restart")
  `PSH_ASSERT_NEXT(a_power_reduced, power_done, power_q < mod_q, "power not below modulus")
  `PSH_ASSERT_IMPLIES(a_reducer_active, in_reduce, red_stat.busy || red_stat.done, "reducer stalled")

endmodule
